// File: hdl/spd_pkg.sv
// shared constants, types and state codes for the spectrum peak detector
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

  localparam int MAX_NFFT         = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // effective transform length is clamped into NFFT_LOG2_LO .. NFFT_LOG2_HI
  localparam int NFFT_LOG2_LO     = 3;
  localparam int NFFT_LOG2_HI_RAW = $clog2(MAX_NFFT + 1) - 1;
  localparam int NFFT_LOG2_HI     = (NFFT_LOG2_HI_RAW < NFFT_LOG2_LO) ?
                                    NFFT_LOG2_LO : NFFT_LOG2_HI_RAW;
  localparam int LG_W             = 5;

  localparam int BIN_CNT_W   = 10;
  localparam int BIN_CNT_MAX = 1023;
  localparam int BIN_W       = 9;
  localparam int SEARCH_CAP  = 512;
  localparam int SEARCH_CAP_LOG2 = 10;
  localparam int FREQ_W      = 18;
  localparam int MAG_W       = 16;
  localparam int MAG_MAX     = 65535;
  localparam int RECIP_W     = 16;
  localparam int FPROD_W     = BIN_W + FREQ_W;

  localparam int OUT_FIELDS_W = BIN_W + FREQ_W + MAG_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NFFT_LOG2   = 3'd0,
    REG_SAMPLE_RATE = 3'd1,
    REG_START_BIN   = 3'd2,
    REG_SCALE_RECIP = 3'd3,
    REG_MIN_STEP    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]         nfft_log2;
    logic [FREQ_W-1:0]  sample_rate_hz;
    logic [BIN_W-1:0]   start_bin;
    logic [RECIP_W-1:0] scale_recip;
    logic [MAG_W-1:0]   min_step;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_SCALE,
    ST_UPDATE,
    ST_FREQ,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

// File: hdl/spectrum_peak_detector.sv
// Spectrum peak detector: finds the strongest FFT bin in the searched range of each frame.
// Bins of one frame enter on the s_axis channel in bin order, real part in
// the low half of tdata, imaginary part above it, tlast on the final bin.
// One result beat per frame leaves on m_axis after the final bin: peak bin,
// its frequency in Hz and its scaled magnitude. Registers are written on the
// cfg channel (always ready) and should only change between frames.
// The front end squares and sums the bin in a registered pipeline and writes
// it to a four-entry queue; it takes a beat every cycle until that fills.
// The back end works on one bin at a time (pop, one square root bit per
// cycle, scale multiply, peak update) and pops the next bin only after the
// peak update of the last, so the bit-serial square root sets the pace.
// The final bin is followed by the frequency multiply and the output load.
// The result sits in an output register: a stalled receiver does not stop
// bins of the next frame, only a second result waits for the first to go.
// Synchronous reset empties the queue, clears the peak state and restores
// the default register values.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_peak_detector #(
  parameter int SAMPLE_WIDTH = spd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // bin_real, bin_imag, zero fill to whole bytes
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  input  logic                                       s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // peak_bin, peak_freq_hz, peak_magnitude, zero fill to whole bytes
  output logic [spd_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [spd_pkg::CFG_INDEX_W-1:0]            cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]             cfg_data
);
  import spd_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SUM_W = 2 * SW;
  localparam int Q_W   = SUM_W + 1;

  cfg_t               cfg;
  logic               push;
  logic               full;
  logic [SUM_W-1:0]   sum_sq;
  logic               sum_last;
  logic [Q_W-1:0]     q_dout;
  logic               q_empty;
  logic               q_pop;
  logic [BIN_W-1:0]   peak_bin;
  logic [FREQ_W-1:0]  peak_freq_hz;
  logic [MAG_W-1:0]   peak_magnitude;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nfft_log2      <= 4'd10;
      cfg.sample_rate_hz <= FREQ_W'(8000);
      cfg.start_bin      <= '0;
      cfg.scale_recip    <= RECIP_W'(65535);
      cfg.min_step       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NFFT_LOG2:   cfg.nfft_log2      <= cfg_data[3:0];
        REG_SAMPLE_RATE: cfg.sample_rate_hz <= cfg_data[FREQ_W-1:0];
        REG_START_BIN:   cfg.start_bin      <= cfg_data[BIN_W-1:0];
        REG_SCALE_RECIP: cfg.scale_recip    <= cfg_data[RECIP_W-1:0];
        REG_MIN_STEP:    cfg.min_step       <= cfg_data[MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spd_front #(
    .SAMPLE_WIDTH (SW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .bin_real (s_axis_tdata[SW-1:0]),
    .bin_imag (s_axis_tdata[2*SW-1:SW]),
    .last_bin (s_axis_tlast),
    .push     (push),
    .full     (full),
    .sum_sq   (sum_sq),
    .sum_last (sum_last)
  );

  spd_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({sum_last, sum_sq}),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  spd_back #(
    .SAMPLE_WIDTH (SW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_sum          (q_dout[SUM_W-1:0]),
    .q_last         (q_dout[SUM_W]),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .peak_bin       (peak_bin),
    .peak_freq_hz   (peak_freq_hz),
    .peak_magnitude (peak_magnitude)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                         peak_magnitude, peak_freq_hz, peak_bin};

endmodule
`default_nettype wire

// File: hdl/spd_front.sv
// front end: takes bins, forms |re|^2 + |im|^2 and hands it to the queue
`timescale 1ns / 1ps
`default_nettype none
module spd_front #(
  parameter int SAMPLE_WIDTH = spd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_WIDTH-1:0]       bin_real,
  input  logic [SAMPLE_WIDTH-1:0]       bin_imag,
  input  logic                          last_bin,
  output logic                          push,
  input  logic                          full,
  output logic [2*SAMPLE_WIDTH-1:0]     sum_sq,
  output logic                          sum_last
);
  import spd_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SQ_W  = 2 * SW - 1;
  localparam int SUM_W = 2 * SW;

  logic              en;
  logic [SW-1:0]     abs_re;
  logic [SW-1:0]     abs_im;
  logic              s1_valid;
  logic [SW-1:0]     s1_abs_re;
  logic [SW-1:0]     s1_abs_im;
  logic              s1_last;
  logic [SUM_W-1:0]  ext_re;
  logic [SUM_W-1:0]  ext_im;
  logic [SUM_W-1:0]  prod_re;
  logic [SUM_W-1:0]  prod_im;
  logic              s2_valid;
  logic [SQ_W-1:0]   s2_sq_re;
  logic [SQ_W-1:0]   s2_sq_im;
  logic              s2_last;

  // whole pipeline holds only when a finished sum cannot enter the queue
  assign en       = !(s2_valid && full);
  assign in_ready = en;
  assign push     = s2_valid && !full;

  assign abs_re = bin_real[SW-1] ? (~bin_real + SW'(1)) : bin_real;
  assign abs_im = bin_imag[SW-1] ? (~bin_imag + SW'(1)) : bin_imag;

  assign ext_re  = {{SW{1'b0}}, s1_abs_re};
  assign ext_im  = {{SW{1'b0}}, s1_abs_im};
  assign prod_re = ext_re * ext_re;
  assign prod_im = ext_im * ext_im;

  assign sum_sq   = {1'b0, s2_sq_re} + {1'b0, s2_sq_im};
  assign sum_last = s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_abs_re <= abs_re;
      s1_abs_im <= abs_im;
      s1_last   <= last_bin;
      s2_sq_re  <= prod_re[SQ_W-1:0];
      s2_sq_im  <= prod_im[SQ_W-1:0];
      s2_last   <= s1_last;
    end
  end

endmodule
`default_nettype wire

// File: hdl/spd_queue.sv
// small register queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module spd_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = spd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import spd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// File: hdl/spd_back.sv
// back end: bit-serial square root, scaling, peak tracking and result register
`timescale 1ns / 1ps
`default_nettype none
module spd_back #(
  parameter int SAMPLE_WIDTH = spd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spd_pkg::cfg_t                   cfg,
  input  logic                            q_empty,
  input  logic [2*SAMPLE_WIDTH-1:0]       q_sum,
  input  logic                            q_last,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spd_pkg::BIN_W-1:0]       peak_bin,
  output logic [spd_pkg::FREQ_W-1:0]      peak_freq_hz,
  output logic [spd_pkg::MAG_W-1:0]       peak_magnitude
);
  import spd_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int X_W    = 2 * SW;
  localparam int REM_W  = SW + 1;
  localparam int TRY_W  = SW + 3;
  localparam int STEP_W = (SW > 1) ? $clog2(SW) : 1;
  localparam int PROD_W = SW + RECIP_W;

  back_state_t        state;
  back_state_t        state_next;

  logic [X_W-1:0]     x;
  logic [REM_W-1:0]   rem;
  logic [SW-1:0]      root;
  logic [STEP_W-1:0]  step_cnt;
  logic               cur_last;
  logic [PROD_W-1:0]  prod;
  logic [BIN_CNT_W-1:0] bin_counter;
  logic [MAG_W-1:0]   best_mag;
  logic [BIN_W-1:0]   best_index;
  logic [FPROD_W-1:0] fprod;

  logic [TRY_W-1:0]   rem_t;
  logic [TRY_W-1:0]   trial;
  logic               root_bit;
  logic [TRY_W-1:0]   rem_sub;
  logic               sqrt_done;
  logic               load_out;

  logic [LG_W-1:0]    nfft_ext;
  logic [LG_W-1:0]    lg_eff;
  logic [BIN_CNT_W-1:0] search_end;
  logic [SW-1:0]      scaled_raw;
  logic [MAG_W-1:0]   scaled_mag;
  logic               in_range;
  logic               better;
  logic [FPROD_W-1:0] freq_shift;

  // one root bit per cycle: bring down two radicand bits, try {root,01}
  assign rem_t    = {rem, x[X_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign root_bit = (rem_t >= trial);
  assign rem_sub  = rem_t - trial;

  // transform length clamp and searched end, capped at the packed bin range
  assign nfft_ext = LG_W'(cfg.nfft_log2);
  always_comb begin
    if (nfft_ext < LG_W'(NFFT_LOG2_LO)) begin
      lg_eff = LG_W'(NFFT_LOG2_LO);
    end else if (nfft_ext > LG_W'(NFFT_LOG2_HI)) begin
      lg_eff = LG_W'(NFFT_LOG2_HI);
    end else begin
      lg_eff = nfft_ext;
    end
  end

  always_comb begin
    if (lg_eff >= LG_W'(SEARCH_CAP_LOG2)) begin
      search_end = BIN_CNT_W'(SEARCH_CAP);
    end else begin
      search_end = BIN_CNT_W'(1) << (lg_eff - LG_W'(1));
    end
  end

  assign scaled_raw = prod[PROD_W-1:RECIP_W];
  assign scaled_mag = ({{RECIP_W{1'b0}}, scaled_raw} > PROD_W'(MAG_MAX)) ?
                      MAG_W'(MAG_MAX) : MAG_W'(scaled_raw);
  assign in_range   = (bin_counter >= {1'b0, cfg.start_bin}) &&
                      (bin_counter < search_end);
  assign better     = ({1'b0, scaled_mag} >
                       ({1'b0, best_mag} + {1'b0, cfg.min_step}));
  assign freq_shift = fprod >> lg_eff;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (!q_empty) state_next = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = cur_last ? ST_FREQ : ST_IDLE;
      ST_FREQ:   state_next = ST_OUT;
      ST_OUT:    if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    sqrt_done = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:  q_pop     = !q_empty;
      ST_SQRT:  sqrt_done = (step_cnt == STEP_W'(SW - 1));
      ST_OUT:   load_out  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      bin_counter <= '0;
      best_mag    <= '0;
      best_index  <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_UPDATE) begin
        if (in_range && better) begin
          best_mag   <= scaled_mag;
          best_index <= bin_counter[BIN_W-1:0];
        end
        if (bin_counter != BIN_CNT_W'(BIN_CNT_MAX)) begin
          bin_counter <= bin_counter + BIN_CNT_W'(1);
        end
      end
      if (load_out) begin
        bin_counter <= '0;
        best_mag    <= '0;
        best_index  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x        <= q_sum;
      cur_last <= q_last;
      rem      <= '0;
      root     <= '0;
      step_cnt <= '0;
    end
    if (state == ST_SQRT) begin
      x        <= {x[X_W-3:0], 2'b00};
      rem      <= root_bit ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
      root     <= {root[SW-2:0], root_bit};
      step_cnt <= step_cnt + STEP_W'(1);
    end
    if (state == ST_SCALE) begin
      prod <= {{RECIP_W{1'b0}}, root} * {{SW{1'b0}}, cfg.scale_recip};
    end
    if (state == ST_FREQ) begin
      fprod <= FPROD_W'(best_index) * FPROD_W'(cfg.sample_rate_hz);
    end
    if (load_out) begin
      peak_bin       <= best_index;
      peak_freq_hz   <= freq_shift[FREQ_W-1:0];
      peak_magnitude <= best_mag;
    end
  end

endmodule
`default_nettype wire
